>>> design/ebl_pkg.sv
`default_nettype none

package ebl_pkg;

  // image geometry
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;

  // pixel store
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned BYTE_W   = 8;

  // filter arithmetic
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned ACC_W    = 16;
  localparam int unsigned ACC_FRAC = 7;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_WEIGHT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_ENABLE  = CFG_IDX_W'(3);

  localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = DIM_W'(256);
  localparam logic [WEIGHT_W-1:0] BLUR_WEIGHT_RST  = '0;
  localparam logic                BLUR_ENABLE_RST  = 1'b0;

  // request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // control from the sequencer to the accumulator unit
  typedef struct packed {
    logic              seed;
    logic              step;
    logic [CHAN_W-1:0] chan;
  } acc_ctl_t;

endpackage

`default_nettype wire

>>> design/ebl_ifs.sv
`default_nettype none

interface ebl_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [ebl_pkg::ADDR_W-1:0]        pixel_index;
  logic [ebl_pkg::PIX_W-1:0]         pixel_value;

  modport source (output valid, req_type, pixel_index, pixel_value, input ready);
  modport sink   (input valid, req_type, pixel_index, pixel_value, output ready);
endinterface

interface ebl_out_if;
  logic                      valid;
  logic                      ready;
  logic [ebl_pkg::PIX_W-1:0] read_data;
  logic                      result_kind;

  modport source (output valid, read_data, result_kind, input ready);
  modport sink   (input valid, read_data, result_kind, output ready);
endinterface

interface ebl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ebl_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [ebl_pkg::CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

>>> design/exponential_image_blur_top.sv
// channel   dir   beat carries
// in_bus    in    req_type, pixel_index, pixel_value (load, run, read)
// out_bus   out   read_data, result_kind (one beat per read or run)
// cfg_bus   in    reg_index, wr_data (always ready)
//
// loads write the store directly, and a read's result beat follows on the next
// cycle; a waiting result beat holds in_bus.ready low until it is taken.
// a run filters each pixel by a read, four channel steps through the one
// multiplier and a write-back, after a seed read and load for each row or column;
// w and h are clamped to MAX_WIDTH and MAX_HEIGHT.
// reset is synchronous; pixel store contents are not cleared.
// in_bus.ready is low for the whole of a run.
`default_nettype none

module exponential_image_blur_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ebl_in_if.sink     in_bus,
  ebl_out_if.source  out_bus,
  ebl_cfg_if.sink    cfg_bus
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_LD,
    ST_PIX_RD,
    ST_CALC,
    ST_WR
  } state_t;

  typedef enum logic [1:0] {
    PASS_ROW_FWD,
    PASS_ROW_BWD,
    PASS_COL_FWD,
    PASS_COL_BWD
  } pass_t;

  localparam logic [ebl_pkg::CHAN_W-1:0] CHAN_LAST = ebl_pkg::CHAN_W'(ebl_pkg::CHANNELS - 1);
  localparam int unsigned DEPTH = 2 ** ebl_pkg::ADDR_W;

  // configuration
  logic [ebl_pkg::DIM_W-1:0]    image_width_r;
  logic [ebl_pkg::DIM_W-1:0]    image_height_r;
  logic [ebl_pkg::WEIGHT_W-1:0] blur_weight_r;
  logic                         blur_enable_r;

  // sequencer
  state_t                        state_r;
  pass_t                         pass_r;
  logic [ebl_pkg::DIM_W-1:0]     outer_r;
  logic [ebl_pkg::DIM_W-1:0]     cnt_r;
  logic [ebl_pkg::ADDR_W-1:0]    addr_r;
  logic [ebl_pkg::CHAN_W-1:0]    chan_r;
  logic                          out_valid_r;
  logic                          out_kind_r;

  // pixel store
  logic [ebl_pkg::PIX_W-1:0]  mem [DEPTH];
  logic [ebl_pkg::PIX_W-1:0]  rdata_r;
  logic                       mem_re;
  logic [ebl_pkg::ADDR_W-1:0] mem_raddr;
  logic                       mem_we;
  logic [ebl_pkg::ADDR_W-1:0] mem_waddr;
  logic [ebl_pkg::PIX_W-1:0]  mem_wdata;

  logic                         in_accept;
  logic                         cfg_accept;
  logic [ebl_pkg::DIM_W-1:0]    w_eff;
  logic [ebl_pkg::DIM_W-1:0]    h_eff;
  logic [ebl_pkg::ADDR_W-1:0]   w_step;
  logic                         blur_go;
  ebl_pkg::acc_ctl_t            acc_ctl;
  logic [ebl_pkg::PIX_W-1:0]    acc_pix;

  assign in_bus.ready = (state_r == ST_IDLE) && (!out_valid_r || out_bus.ready);
  assign in_accept    = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign cfg_accept    = cfg_bus.valid;

  always_comb begin
    w_eff = (32'(image_width_r) > ebl_pkg::MAX_WIDTH) ?
            ebl_pkg::DIM_W'(ebl_pkg::MAX_WIDTH) : image_width_r;
    h_eff = (32'(image_height_r) > ebl_pkg::MAX_HEIGHT) ?
            ebl_pkg::DIM_W'(ebl_pkg::MAX_HEIGHT) : image_height_r;
    w_step  = {{(ebl_pkg::ADDR_W - ebl_pkg::DIM_W){1'b0}}, w_eff};
    blur_go = blur_enable_r && (w_eff != '0) && (h_eff != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= ebl_pkg::IMAGE_WIDTH_RST;
      image_height_r <= ebl_pkg::IMAGE_HEIGHT_RST;
      blur_weight_r  <= ebl_pkg::BLUR_WEIGHT_RST;
      blur_enable_r  <= ebl_pkg::BLUR_ENABLE_RST;
    end else if (cfg_accept) begin
      case (cfg_bus.reg_index)
        ebl_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_bus.wr_data[ebl_pkg::DIM_W-1:0];
        ebl_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_bus.wr_data[ebl_pkg::DIM_W-1:0];
        ebl_pkg::REG_BLUR_WEIGHT:  blur_weight_r  <= cfg_bus.wr_data[ebl_pkg::WEIGHT_W-1:0];
        ebl_pkg::REG_BLUR_ENABLE:  blur_enable_r  <= cfg_bus.wr_data[0];
        default: ;
      endcase
    end
  end

  // store port selection: item path while idle, sequencer during a run
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = addr_r;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = acc_pix;
    case (state_r)
      ST_IDLE: begin
        mem_raddr = in_bus.pixel_index;
        mem_waddr = in_bus.pixel_index;
        mem_wdata = in_bus.pixel_value;
        mem_re    = in_accept && (in_bus.req_type == ebl_pkg::REQ_READ);
        mem_we    = in_accept && (in_bus.req_type == ebl_pkg::REQ_LOAD);
      end
      ST_SEED_RD, ST_PIX_RD: mem_re = 1'b1;
      ST_WR:                 mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    acc_ctl.seed = (state_r == ST_SEED_LD);
    acc_ctl.step = (state_r == ST_CALC);
    acc_ctl.chan = chan_r;
  end

  ebl_acc_unit u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .weight  (blur_weight_r),
    .pix_in  (rdata_r),
    .pix_out (acc_pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= PASS_ROW_FWD;
      outer_r     <= '0;
      cnt_r       <= '0;
      addr_r      <= '0;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_bus.req_type)
              ebl_pkg::REQ_READ: begin
                out_valid_r <= 1'b1;
                out_kind_r  <= ebl_pkg::KIND_READ;
              end
              ebl_pkg::REQ_RUN: begin
                if (blur_go) begin
                  pass_r  <= PASS_ROW_FWD;
                  outer_r <= '0;
                  addr_r  <= '0;
                  cnt_r   <= w_eff;
                  state_r <= ST_SEED_RD;
                end else begin
                  out_valid_r <= 1'b1;
                  out_kind_r  <= ebl_pkg::KIND_RUN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEED_RD: state_r <= ST_SEED_LD;
        ST_SEED_LD: begin
          // a column seed skips row 0; with two rows only the backward pass runs
          if (pass_r == PASS_COL_FWD) begin
            if (h_eff == ebl_pkg::DIM_W'(2)) begin
              pass_r <= PASS_COL_BWD;
              cnt_r  <= ebl_pkg::DIM_W'(1);
            end else begin
              addr_r <= addr_r + w_step;
              cnt_r  <= h_eff - ebl_pkg::DIM_W'(2);
            end
          end
          state_r <= ST_PIX_RD;
        end
        ST_PIX_RD: begin
          chan_r  <= '0;
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          chan_r <= chan_r + ebl_pkg::CHAN_W'(1);
          if (chan_r == CHAN_LAST) begin
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          state_r <= ST_PIX_RD;
          cnt_r   <= cnt_r - ebl_pkg::DIM_W'(1);
          case (pass_r)
            PASS_ROW_FWD, PASS_ROW_BWD: begin
              if (cnt_r != ebl_pkg::DIM_W'(1)) begin
                addr_r <= (pass_r == PASS_ROW_FWD) ? addr_r + ebl_pkg::ADDR_W'(1) :
                                                     addr_r - ebl_pkg::ADDR_W'(1);
              end else if (pass_r == PASS_ROW_FWD && w_eff != ebl_pkg::DIM_W'(1)) begin
                pass_r <= PASS_ROW_BWD;
                addr_r <= addr_r - ebl_pkg::ADDR_W'(1);
                cnt_r  <= w_eff - ebl_pkg::DIM_W'(1);
              end else if (outer_r != h_eff - ebl_pkg::DIM_W'(1)) begin
                // row done: addr_r sits on the row base
                pass_r  <= PASS_ROW_FWD;
                outer_r <= outer_r + ebl_pkg::DIM_W'(1);
                addr_r  <= addr_r + w_step;
                cnt_r   <= w_eff;
                state_r <= ST_SEED_RD;
              end else if (h_eff != ebl_pkg::DIM_W'(1)) begin
                pass_r  <= PASS_COL_FWD;
                outer_r <= '0;
                addr_r  <= '0;
                state_r <= ST_SEED_RD;
              end else begin
                out_valid_r <= 1'b1;
                out_kind_r  <= ebl_pkg::KIND_RUN;
                state_r     <= ST_IDLE;
              end
            end
            PASS_COL_FWD: begin
              if (cnt_r != ebl_pkg::DIM_W'(1)) begin
                addr_r <= addr_r + w_step;
              end else begin
                // backward pass starts on the same row
                pass_r <= PASS_COL_BWD;
                cnt_r  <= h_eff - ebl_pkg::DIM_W'(1);
              end
            end
            default: begin
              if (cnt_r != ebl_pkg::DIM_W'(1)) begin
                addr_r <= addr_r - w_step;
              end else if (outer_r != w_eff - ebl_pkg::DIM_W'(1)) begin
                pass_r  <= PASS_COL_FWD;
                outer_r <= outer_r + ebl_pkg::DIM_W'(1);
                addr_r  <= {{(ebl_pkg::ADDR_W - ebl_pkg::DIM_W){1'b0}},
                            outer_r + ebl_pkg::DIM_W'(1)};
                state_r <= ST_SEED_RD;
              end else begin
                out_valid_r <= 1'b1;
                out_kind_r  <= ebl_pkg::KIND_RUN;
                state_r     <= ST_IDLE;
              end
            end
          endcase
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.result_kind = out_kind_r;
  assign out_bus.read_data   = (out_kind_r == ebl_pkg::KIND_RUN) ? '0 : rdata_r;

endmodule

`default_nettype wire

>>> design/ebl_acc_unit.sv
`default_nettype none

module ebl_acc_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ebl_pkg::acc_ctl_t                  ctl,
  input  wire logic [ebl_pkg::WEIGHT_W-1:0]       weight,
  input  wire logic [ebl_pkg::PIX_W-1:0]          pix_in,
  output logic [ebl_pkg::PIX_W-1:0]               pix_out
);

  logic signed [ebl_pkg::ACC_W-1:0] acc_r [ebl_pkg::CHANNELS];
  logic [ebl_pkg::PIX_W-1:0]        res_r;

  logic [ebl_pkg::BYTE_W-1:0]              byte_sel;
  logic signed [ebl_pkg::ACC_W-1:0]        tgt;
  logic signed [ebl_pkg::ACC_W-1:0]        z_cur;
  logic signed [ebl_pkg::ACC_W:0]          diff;
  logic signed [ebl_pkg::WEIGHT_W:0]       weight_s;
  logic signed [ebl_pkg::WEIGHT_W+ebl_pkg::ACC_W+1:0] prod;
  logic signed [ebl_pkg::ACC_W:0]          q;
  logic signed [ebl_pkg::ACC_W:0]          z_sum;
  logic [ebl_pkg::ACC_W-1:0]               z_nxt;

  // one channel per cycle through the shared multiplier
  always_comb begin
    byte_sel = pix_in[ebl_pkg::BYTE_W*ctl.chan +: ebl_pkg::BYTE_W];
    tgt      = {1'b0, byte_sel, {ebl_pkg::ACC_FRAC{1'b0}}};
    z_cur    = acc_r[ctl.chan];
    diff     = {tgt[ebl_pkg::ACC_W-1], tgt} - {z_cur[ebl_pkg::ACC_W-1], z_cur};
    weight_s = {1'b0, weight};
    prod     = weight_s * diff;
    // arithmetic shift floors towards minus infinity
    q        = prod[ebl_pkg::WEIGHT_W+ebl_pkg::ACC_W:ebl_pkg::WEIGHT_W];
    z_sum    = {z_cur[ebl_pkg::ACC_W-1], z_cur} + q;
    z_nxt    = z_sum[ebl_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < ebl_pkg::CHANNELS; c++) begin
        acc_r[c] <= '0;
      end
    end else if (ctl.seed) begin
      for (int c = 0; c < ebl_pkg::CHANNELS; c++) begin
        acc_r[c] <= {1'b0, pix_in[ebl_pkg::BYTE_W*c +: ebl_pkg::BYTE_W],
                     {ebl_pkg::ACC_FRAC{1'b0}}};
      end
    end else if (ctl.step) begin
      acc_r[ctl.chan] <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      res_r[ebl_pkg::BYTE_W*ctl.chan +: ebl_pkg::BYTE_W] <=
        z_nxt[ebl_pkg::ACC_FRAC +: ebl_pkg::BYTE_W];
    end
  end

  assign pix_out = res_r;

endmodule

`default_nettype wire

>>> design/ebl_checker.sv
`default_nettype none

module ebl_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [1:0]                 in_req_type,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ebl_pkg::PIX_W-1:0]  out_read_data,
  input wire logic                       out_result_kind
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_result_kind))
    else $error("stalled result beat changed");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == ebl_pkg::REQ_READ
    |=> out_valid && out_result_kind == ebl_pkg::KIND_READ)
    else $error("read did not return a result on the next cycle");

  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == ebl_pkg::KIND_RUN |-> out_read_data == '0)
    else $error("run completion carries non-zero data");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == ebl_pkg::REQ_LOAD && !out_valid
    |=> !out_valid)
    else $error("load produced a result beat");

endmodule

bind exponential_image_blur_top ebl_checker u_ebl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .in_req_type     (in_bus.req_type),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_read_data   (out_bus.read_data),
  .out_result_kind (out_bus.result_kind)
);

`default_nettype wire
